[rtl/lzw_pkg.sv]
// Shared constants, types and state codes of the LZW compressor.
package lzw_pkg;

	localparam int DICT_SIZE   = 4096;
	localparam int CODE_W      = 12;
	localparam int CODE_SPACE  = 1 << CODE_W;
	localparam int CODE_LIMIT  = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
	localparam int NFC_W       = CODE_W + 1;
	localparam int BYTE_W      = 8;
	localparam int ROOT_CODES  = 1 << BYTE_W;
	localparam int KEY_W       = CODE_W + BYTE_W;

	// dictionary banking across the cell chain: code = {row, cell}
	localparam int NUM_CELLS   = 64;
	localparam int CELL_W      = $clog2(NUM_CELLS);
	localparam int ROW_W       = CODE_W - CELL_W;
	localparam int ROW_DEPTH   = 1 << ROW_W;
	localparam int FIRST_ROW   = ROOT_CODES / NUM_CELLS;

	// two read/compare stages in a cell, then the chain itself
	localparam int DRAIN_CYCLES = NUM_CELLS + 2;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

	localparam int OQ_DEPTH    = 4;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = OQ_PTR_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              scan;
		logic [ROW_W-1:0]  row;
		logic [KEY_W-1:0]  key;
		logic [NFC_W-1:0]  nfc;
		logic              wr_en;
		logic [CODE_W-1:0] wr_code;
	} cell_ctrl_t;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} chain_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} result_t;

endpackage

[rtl/lzw_if.sv]
// Byte input and code output channel interfaces.
interface lzw_in_if import lzw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzw_out_if import lzw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;
	logic              last_code;

	modport source (output valid, output code, output last_code, input ready);
	modport sink   (input valid, input code, input last_code, output ready);
endinterface

[rtl/lzw_cell.sv]
// One dictionary cell: a bank of entries, a comparator and a link of the hit chain.
module lzw_cell import lzw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CELL_W-1:0] id,
	input  cell_ctrl_t        ctrl,
	input  chain_t            prev,
	output chain_t            next
);

	logic [KEY_W-1:0]  mem [ROW_DEPTH];
	logic [KEY_W-1:0]  rd_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              vld_s1;
	logic [CODE_W-1:0] own_code;
	logic              lookup_ok;
	logic              match;
	logic              loc_hit_q;
	logic [CODE_W-1:0] loc_code_q;
	logic              chain_hit_q;
	logic [CODE_W-1:0] chain_code_q;

	// only learned codes below the fill count hold live entries
	assign own_code  = {ctrl.row, id};
	assign lookup_ok = ctrl.scan && (own_code >= CODE_W'(ROOT_CODES)) &&
		({1'b0, own_code} < ctrl.nfc);

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_code[CELL_W-1:0] == id)) begin
			mem[ctrl.wr_code[CODE_W-1:CELL_W]] <= ctrl.key;
		end
		rd_s1  <= mem[ctrl.row];
		row_s1 <= ctrl.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= lookup_ok;
		end
	end

	assign match = vld_s1 && (rd_s1 == ctrl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			loc_hit_q <= 1'b0;
		end else if (match) begin
			loc_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			loc_code_q <= {row_s1, id};
		end
	end

	// pass the hit toward the end of the chain; entries are unique, so at most one cell hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			chain_hit_q <= 1'b0;
		end else begin
			chain_hit_q <= prev.hit | loc_hit_q;
		end
	end

	always_ff @(posedge clk) begin
		chain_code_q <= loc_hit_q ? loc_code_q : prev.code;
	end

	assign next.hit  = chain_hit_q;
	assign next.code = chain_code_q;

endmodule

[rtl/lzw_outq.sv]
// Result queue: takes up to two codes a cycle, hands one out per transaction.
module lzw_outq import lzw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    a_valid,
	input  result_t a_data,
	input  logic    b_valid,
	input  result_t b_data,
	output logic    room2,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t               q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wp_q;
	logic [OQ_PTR_W-1:0]   rp_q;
	logic [OQ_CNT_W-1:0]   cnt_q;
	logic [OQ_PTR_W-1:0]   b_addr;
	logic [1:0]            n_push;
	logic                  pop;

	assign b_addr   = a_valid ? (wp_q + OQ_PTR_W'(1)) : wp_q;
	assign n_push   = {1'b0, a_valid} + {1'b0, b_valid};
	assign out_valid = (cnt_q != '0);
	assign pop      = out_valid && out_ready;
	assign out_data = q[rp_q];
	assign room2    = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (a_valid) begin
			q[wp_q] <= a_data;
		end
		if (b_valid) begin
			q[b_addr] <= b_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OQ_PTR_W'(n_push);
			rp_q  <= rp_q + OQ_PTR_W'(pop);
			cnt_q <= cnt_q + OQ_CNT_W'(n_push) - OQ_CNT_W'(pop);
		end
	end

endmodule

[rtl/lzw_compressor_top.sv]
// Fixed-width 12-bit LZW compressor: sequencer, cell chain and result queue.
// First byte of a stream: taken in the idle state, no search.
// Other bytes: accept, scan rows 4 up to the row of the last learned code (at least one row),
// drain through the two cell stages and the 64-cell hit chain, then decide; each cell banks 64 rows.
// Results enter a 4-deep queue at the end of the decide cycle and are offered from it in order.
// Reset (async, active low) clears control and the queue; the dictionary is gated by the fill count.
module lzw_compressor_top import lzw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lzw_in_if.sink    raw,
	lzw_out_if.source codes
);

	state_t            state_q;
	state_t            state_nxt;
	logic [NFC_W-1:0]  nfc_q;
	logic [CODE_W-1:0] cur_q;
	logic              have_q;
	logic [KEY_W-1:0]  key_q;
	logic              last_q;
	logic [ROW_W-1:0]  row_q;
	logic [DRAIN_W-1:0] drain_q;

	logic              in_ready;
	logic              scan_en;
	logic              decide_en;
	logic              accept;
	logic              room2;
	logic [NFC_W-1:0]  nfc_m1;
	logic [ROW_W-1:0]  last_row;
	logic              scan_done;
	logic              drain_done;
	logic              can_add;
	logic [CODE_W-1:0] new_cur;
	chain_t            found;
	cell_ctrl_t        ctrl;
	chain_t            links [NUM_CELLS+1];

	logic              push_a_valid;
	result_t           push_a;
	logic              push_b_valid;
	result_t           push_b;
	result_t           out_data;

	assign nfc_m1     = nfc_q - NFC_W'(1);
	assign last_row   = nfc_m1[CODE_W-1:CELL_W];
	assign scan_done  = (row_q >= last_row);
	assign drain_done = (drain_q == DRAIN_W'(DRAIN_CYCLES - 1));
	assign can_add    = (nfc_q < NFC_W'(CODE_LIMIT));
	assign found      = links[NUM_CELLS];
	assign new_cur    = found.hit ? found.code : CODE_W'(key_q[BYTE_W-1:0]);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && have_q) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		scan_en   = 1'b0;
		decide_en = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready  = room2;
			ST_SCAN:   scan_en   = 1'b1;
			ST_DRAIN:  ;
			ST_DECIDE: decide_en = 1'b1;
			default:   ;
		endcase
	end

	assign raw.ready = in_ready;
	assign accept    = raw.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nfc_q   <= NFC_W'(ROOT_CODES);
			have_q  <= 1'b0;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				row_q   <= ROW_W'(FIRST_ROW);
				drain_q <= '0;
				if (!have_q) begin
					have_q <= !raw.end_of_stream;
				end
			end
			if (scan_en && !scan_done) begin
				row_q <= row_q + ROW_W'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + DRAIN_W'(1);
			end
			if (decide_en) begin
				if (last_q) begin
					nfc_q  <= NFC_W'(ROOT_CODES);
					have_q <= 1'b0;
				end else if (!found.hit && can_add) begin
					nfc_q <= nfc_q + NFC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= {cur_q, raw.data_byte};
			last_q <= raw.end_of_stream;
			if (!have_q) begin
				cur_q <= CODE_W'(raw.data_byte);
			end
		end
		if (decide_en) begin
			cur_q <= new_cur;
		end
	end

	assign ctrl.clear   = accept && have_q;
	assign ctrl.scan    = scan_en;
	assign ctrl.row     = row_q;
	assign ctrl.key     = key_q;
	assign ctrl.nfc     = nfc_q;
	assign ctrl.wr_en   = decide_en && !found.hit && can_add;
	assign ctrl.wr_code = nfc_q[CODE_W-1:0];

	assign links[0] = '0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		lzw_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.id     (CELL_W'(g)),
			.ctrl   (ctrl),
			.prev   (links[g]),
			.next   (links[g+1])
		);
	end

	// miss emits the current string; the final byte adds the flush code
	assign push_a_valid = decide_en && !found.hit;
	assign push_a.code  = cur_q;
	assign push_a.last  = 1'b0;
	assign push_b_valid = (decide_en && last_q) || (accept && !have_q && raw.end_of_stream);
	assign push_b.code  = decide_en ? new_cur : CODE_W'(raw.data_byte);
	assign push_b.last  = 1'b1;

	lzw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.a_valid   (push_a_valid),
		.a_data    (push_a),
		.b_valid   (push_b_valid),
		.b_data    (push_b),
		.room2     (room2),
		.out_valid (codes.valid),
		.out_ready (codes.ready),
		.out_data  (out_data)
	);

	assign codes.code      = out_data.code;
	assign codes.last_code = out_data.last;

endmodule

[rtl/lzw_checker.sv]
// Port-level checks of the LZW compressor, bound to the top level.
module lzw_checker import lzw_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_eos,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CODE_W-1:0] out_code,
	input logic              out_last
);

	logic [3:0] pend_q;
	logic       eos_in;
	logic       last_out;

	assign eos_in   = in_valid && in_ready && in_eos;
	assign last_out = out_valid && out_ready && out_last;

	// count streams closed at the input whose final code has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(eos_in) - 4'(last_out);
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
		else $error("stalled result changed");

	a_last_needs_eos: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> (pend_q != 4'd0))
		else $error("final code without a final byte");

endmodule

bind lzw_compressor_top lzw_checker u_lzw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (raw.valid),
	.in_ready  (raw.ready),
	.in_eos    (raw.end_of_stream),
	.out_valid (codes.valid),
	.out_ready (codes.ready),
	.out_code  (codes.code),
	.out_last  (codes.last_code)
);
